>>> hw/rtl/hsd_pkg.sv
`timescale 1ns / 1ps
package hsd_pkg;

	localparam int THR_W = 8;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		CMD_EDGE   = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_FORCE  = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'b001,
		PH_SHORT = 3'b010,
		PH_LONG  = 3'b100
	} phase_t;

	localparam logic [CFG_IDX_W-1:0] REG_OLD_STYLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 2'd2;

	localparam logic [THR_W-1:0] SHORT_TICKS_RST = 8'd4;
	localparam logic [THR_W-1:0] LONG_TICKS_RST  = 8'd16;

	typedef struct packed {
		logic [1:0] cmd;
		logic       hook_sample;
	} item_t;

	typedef struct packed {
		logic hook_state;
		logic notify_change;
		logic intr_enable;
		logic look_for_offhook;
		logic timer_arm;
		logic misuse;
	} result_t;

endpackage

>>> hw/rtl/hsd_item_if.sv
`timescale 1ns / 1ps
interface hsd_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic       hook_sample;

	modport source (output valid, output cmd, output hook_sample, input ready);
	modport sink (input valid, input cmd, input hook_sample, output ready);
endinterface

>>> hw/rtl/hsd_result_if.sv
`timescale 1ns / 1ps
interface hsd_result_if;
	logic valid;
	logic ready;
	logic hook_state;
	logic notify_change;
	logic intr_enable;
	logic look_for_offhook;
	logic timer_arm;
	logic misuse;

	modport source (output valid, output hook_state, output notify_change, output intr_enable,
		output look_for_offhook, output timer_arm, output misuse, input ready);
	modport sink (input valid, input hook_state, input notify_change, input intr_enable,
		input look_for_offhook, input timer_arm, input misuse, output ready);
endinterface

>>> hw/rtl/hsd_cfg_if.sv
`timescale 1ns / 1ps
interface hsd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> hw/rtl/hookswitch_two_stage_debouncer.sv
`timescale 1ns / 1ps
// Hook switch qualifier with a two-stage (short, then long) tick debounce, or
// direct level tracking when old_style is set. Channels:
//   item   - sink: cmd (edge interrupt, debounce tick, forced set) and the
//            sampled switch level.
//   result - source: one result per item with hook state, change notify,
//            interrupt re-arm and polarity, timer arm and misuse flag.
//   cfg    - sink: register writes (old_style, short_ticks, long_ticks),
//            always ready; write only while no item is in flight.
// An accepted item passes one input register and then one result register;
// the state update sits between the two registers.
// Throughput: one item per cycle while the receiver takes results; the state
// update is the only loop, and it does not limit back-to-back items.
// When the receiver stalls, the result register holds and the input register
// fills; item.ready then drops until the result is taken.
// Reset: hook state on hook, waiting for an edge, tick count zero, registers
// at old_style 0, short_ticks 4, long_ticks 16, both stages empty.
module hookswitch_two_stage_debouncer #(
	parameter int TICK_COUNT_WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	hsd_item_if.sink     item,
	hsd_result_if.source result,
	hsd_cfg_if.sink      cfg
);
	import hsd_pkg::*;

	localparam int CMP_W = (TICK_COUNT_WIDTH > THR_W) ? TICK_COUNT_WIDTH : THR_W;

	logic                        old_style_q;
	logic [THR_W-1:0]            short_ticks_q;
	logic [THR_W-1:0]            long_ticks_q;

	logic                        acc_q;
	phase_t                      phase_q;
	logic                        cand_q;
	logic [TICK_COUNT_WIDTH-1:0] cnt_q;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;

	logic advance;

	logic                        acc_n;
	phase_t                      phase_n;
	logic                        cand_n;
	logic [TICK_COUNT_WIDTH-1:0] cnt_n;
	logic [TICK_COUNT_WIDTH-1:0] cnt_inc;
	logic [THR_W-1:0]            need;
	logic                        in_db;
	logic                        lvl;
	result_t                     res_n;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_style_q   <= 1'b0;
			short_ticks_q <= SHORT_TICKS_RST;
			long_ticks_q  <= LONG_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OLD_STYLE:   old_style_q   <= cfg.wdata[0];
				REG_SHORT_TICKS: short_ticks_q <= cfg.wdata;
				REG_LONG_TICKS:  long_ticks_q  <= cfg.wdata;
				default: ;
			endcase
		end
	end

	assign lvl     = item_s1.hook_sample;
	assign in_db   = (phase_q == PH_SHORT) || (phase_q == PH_LONG);
	assign cnt_inc = (cnt_q == {TICK_COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + 1'b1;
	assign need    = (phase_q == PH_SHORT) ? short_ticks_q : long_ticks_q;

	always_comb begin
		acc_n   = acc_q;
		phase_n = phase_q;
		cand_n  = cand_q;
		cnt_n   = cnt_q;
		res_n   = '0;
		if (old_style_q && item_s1.cmd != CMD_UNUSED) begin
			if (lvl != acc_q) begin
				acc_n               = lvl;
				res_n.notify_change = 1'b1;
				res_n.timer_arm     = 1'b1;
			end else begin
				res_n.intr_enable = 1'b1;
			end
		end else begin
			case (item_s1.cmd)
				CMD_EDGE: begin
					if (in_db) begin
						res_n.misuse = 1'b1;
					end else if (lvl != acc_q) begin
						cand_n          = lvl;
						cnt_n           = '0;
						phase_n         = PH_SHORT;
						res_n.timer_arm = 1'b1;
					end else begin
						res_n.intr_enable = 1'b1;
					end
				end
				CMD_TICK: begin
					cnt_n = cnt_inc;
					if (in_db) begin
						// a bounce restarts the stable count on the new level
						if (cand_q != lvl) begin
							cand_n = lvl;
							cnt_n  = '0;
						end
						if (CMP_W'(cnt_n) >= CMP_W'(need)) begin
							if (cand_n != acc_q) begin
								acc_n               = lvl;
								res_n.notify_change = 1'b1;
								phase_n = (phase_q == PH_SHORT) ? PH_LONG : PH_WAIT;
							end else begin
								phase_n = PH_WAIT;
							end
							cnt_n = '0;
						end
					end else begin
						res_n.misuse = 1'b1;
						phase_n      = PH_WAIT;
					end
					if (phase_n == PH_WAIT) begin
						res_n.intr_enable = 1'b1;
					end else begin
						res_n.timer_arm = 1'b1;
					end
				end
				CMD_FORCE: begin
					if (lvl != acc_q) begin
						acc_n               = lvl;
						res_n.notify_change = 1'b1;
					end
				end
				default: ;
			endcase
		end
		res_n.hook_state       = acc_n;
		res_n.look_for_offhook = !acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= 1'b0;
			phase_q  <= PH_WAIT;
			cand_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				acc_q    <= acc_n;
				phase_q  <= phase_n;
				cand_q   <= cand_n;
				cnt_q    <= cnt_n;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cmd         <= item.cmd;
			item_s1.hook_sample <= item.hook_sample;
		end
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	assign result.valid            = valid_s2;
	assign result.hook_state       = res_s2.hook_state;
	assign result.notify_change    = res_s2.notify_change;
	assign result.intr_enable      = res_s2.intr_enable;
	assign result.look_for_offhook = res_s2.look_for_offhook;
	assign result.timer_arm        = res_s2.timer_arm;
	assign result.misuse           = res_s2.misuse;

endmodule

>>> hw/rtl/hsd_checker.sv
`timescale 1ns / 1ps
module hsd_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic hook_state,
	input logic notify_change,
	input logic intr_enable,
	input logic look_for_offhook,
	input logic timer_arm,
	input logic misuse
);

	// polarity always watches for the opposite of the accepted state
	a_polarity: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (look_for_offhook == !hook_state))
		else $error("polarity does not oppose hook state");

	a_arm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(intr_enable && timer_arm))
		else $error("interrupt re-arm and timer arm together");

	a_misuse_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && misuse) |-> !notify_change)
		else $error("misuse transaction changed hook state");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(hook_state)
			&& $stable(notify_change) && $stable(intr_enable) && $stable(timer_arm)
			&& $stable(misuse)))
		else $error("stalled result changed");

endmodule

bind hookswitch_two_stage_debouncer hsd_checker u_hsd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.hook_state       (result.hook_state),
	.notify_change    (result.notify_change),
	.intr_enable      (result.intr_enable),
	.look_for_offhook (result.look_for_offhook),
	.timer_arm        (result.timer_arm),
	.misuse           (result.misuse)
);
